/* hdl/bdlp_pkg.sv */
// ----------------------------------------------------------------------------
// bdlp_pkg: shared types and codes for the button debouncer
// Event codes, command codes, register indexes and the structs that travel
// between the per-button cells, the priority pick and the top level.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  // Fixed field widths.
  localparam int LEVEL_W = 5;
  localparam int KIND_W  = 3;
  localparam int BTN_W   = 3;
  localparam int HELD_W  = 16;
  localparam int CMD_W   = 3;
  localparam int CFG_W   = 16;

  // Event kinds.
  localparam logic [KIND_W-1:0] EV_NONE   = 3'd0;
  localparam logic [KIND_W-1:0] EV_CLICK  = 3'd1;
  localparam logic [KIND_W-1:0] EV_LSTART = 3'd2;
  localparam logic [KIND_W-1:0] EV_LHOLD  = 3'd3;
  localparam logic [KIND_W-1:0] EV_LSTOP  = 3'd4;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MODE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UP    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DOWN  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_STOP5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_NAP   = 3'd6;

  // Button positions.
  localparam logic [4:0] BTN_TOP   = 5'd0;
  localparam logic [4:0] BTN_UP    = 5'd1;
  localparam logic [4:0] BTN_DOWN  = 5'd2;
  localparam logic [4:0] BTN_LEFT  = 5'd3;
  localparam logic [4:0] BTN_RIGHT = 5'd4;

  // Register indexes.
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_LONG     = 1'b1;

  // Reset values of the registers.
  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_press_ms;
  } bdlp_cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [HELD_W-1:0] held;
  } bdlp_ev_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BTN_W-1:0]  button;
    logic [HELD_W-1:0] held;
    logic [CMD_W-1:0]  command;
  } bdlp_res_t;

  // Command for an event on a given button index.
  function automatic logic [CMD_W-1:0] map_cmd(input logic [KIND_W-1:0] kind,
                                               input logic [4:0] btn);
    logic [CMD_W-1:0] cmd;
    cmd = CMD_NONE;
    if (kind == EV_CLICK) begin
      case (btn)
        BTN_TOP:   cmd = CMD_STOP5;
        BTN_UP:    cmd = CMD_UP;
        BTN_DOWN:  cmd = CMD_DOWN;
        BTN_LEFT:  cmd = CMD_MODE;
        BTN_RIGHT: cmd = CMD_SET;
        default:   cmd = CMD_NONE;
      endcase
    end else if (kind == EV_LSTART && btn == BTN_TOP) begin
      cmd = CMD_NAP;
    end
    return cmd;
  endfunction

endpackage

/* hdl/bdlp_button.sv */
// ----------------------------------------------------------------------------
// bdlp_button: one button's debounce and press tracking
// Holds the previous raw level, the debounced level, the long-press flag and
// the quiet timer, and derives this tick's event from them.
// ----------------------------------------------------------------------------
module bdlp_button
  import bdlp_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      raw,
  input  bdlp_cfg_t cfg,
  output bdlp_ev_t  ev
);

  localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  logic                  raw_prev_r;
  logic                  stable_r, stable_nxt;
  logic                  long_r, long_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic [CW-1:0]         timer_wide;
  logic                  was_pressed, is_pressed;

  // Quiet timer restarts on a raw change and saturates at its maximum.
  always_comb begin
    if (raw != raw_prev_r) begin
      timer_nxt = '0;
    end else if (timer_r != TMAX) begin
      timer_nxt = timer_r + 1'b1;
    end else begin
      timer_nxt = timer_r;
    end
  end

  assign timer_wide = CW'(timer_nxt);
  assign stable_nxt = (timer_wide > CW'(cfg.debounce_ms)) ? raw : stable_r;
  assign was_pressed = !stable_r;
  assign is_pressed  = !stable_nxt;

  // Event rules from the old and new debounced levels.
  always_comb begin
    long_nxt = long_r;
    ev.kind  = EV_NONE;
    if (was_pressed && !is_pressed) begin
      if (long_r) begin
        long_nxt = 1'b0;
        ev.kind  = EV_LSTOP;
      end else begin
        ev.kind  = EV_CLICK;
      end
    end else if (is_pressed && (timer_wide > CW'(cfg.long_press_ms))) begin
      long_nxt = 1'b1;
      ev.kind  = long_r ? EV_LHOLD : EV_LSTART;
    end
    ev.held = (ev.kind == EV_LHOLD || ev.kind == EV_LSTOP) ?
              timer_wide[HELD_W-1:0] : '0;
  end

  // State advances when the tick word moves to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_prev_r <= 1'b1;
      stable_r   <= 1'b1;
      long_r     <= 1'b0;
      timer_r    <= '0;
    end else if (adv) begin
      raw_prev_r <= raw;
      stable_r   <= stable_nxt;
      long_r     <= long_nxt;
      timer_r    <= timer_nxt;
    end
  end

endmodule

/* hdl/bdlp_pick.sv */
// ----------------------------------------------------------------------------
// bdlp_pick: priority selection of the reported event
// The highest-numbered button with an event wins; its command is mapped.
// ----------------------------------------------------------------------------
module bdlp_pick
  import bdlp_pkg::*;
#(
  parameter int NUM_BUTTONS = 5
) (
  input  bdlp_ev_t  ev [NUM_BUTTONS],
  output bdlp_res_t res
);

  logic [KIND_W-1:0] kind;
  logic [HELD_W-1:0] held;
  logic [4:0]        win;

  // Later buttons override earlier ones.
  always_comb begin
    kind = EV_NONE;
    held = '0;
    win  = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (ev[i].kind != EV_NONE) begin
        kind = ev[i].kind;
        held = ev[i].held;
        win  = 5'(i);
      end
    end
  end

  assign res.kind    = kind;
  assign res.button  = win[BTN_W-1:0];
  assign res.held    = held;
  assign res.command = map_cmd(kind, win);

endmodule

/* hdl/button_debounce_long_press.sv */
// ----------------------------------------------------------------------------
// button_debounce_long_press: debouncer with click and long-press events
// Timing: a tick word moves from the input register to the result register
// when the result register is free or taken. Throughput: one tick word per
// cycle unless out_stall holds the result; the per-button timer update and
// the priority pick run in one pass between the input and result registers.
// Reset (synchronous, rst_n low): buttons released, timers and long flags
// cleared, debounce_ms 50 and long_press_ms 1000, both registers empty.
// ----------------------------------------------------------------------------
module button_debounce_long_press
  import bdlp_pkg::*;
#(
  parameter int NUM_BUTTONS = 5,
  parameter int TIMER_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [LEVEL_W-1:0] in_levels,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [KIND_W-1:0]  out_event_kind,
  output logic [BTN_W-1:0]   out_button,
  output logic [HELD_W-1:0]  out_held_time,
  output logic [CMD_W-1:0]   out_command,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  bdlp_cfg_t          cfg_r;
  logic               s1_valid_r;
  logic [LEVEL_W-1:0] s1_levels_r;
  logic               out_valid_r;
  bdlp_res_t          res, res_r;
  bdlp_ev_t           ev [NUM_BUTTONS];
  logic               in_acc, adv;

  // Handshake: the input register moves on when the result register frees.
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms   <= DEBOUNCE_RST;
      cfg_r.long_press_ms <= LONG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE: cfg_r.debounce_ms   <= cfg_wdata;
        REG_LONG:     cfg_r.long_press_ms <= cfg_wdata;
        default:      cfg_r               <= cfg_r;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_levels_r <= in_levels;
    end
  end

  // Per-button cells; buttons past the levels field read as pressed.
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    logic raw;
    if (i < LEVEL_W) begin : g_pin
      assign raw = s1_levels_r[i];
    end else begin : g_none
      assign raw = 1'b0;
    end
    bdlp_button #(.TIMER_BITS(TIMER_BITS)) u_btn (
      .clk  (clk),
      .rst_n(rst_n),
      .adv  (adv),
      .raw  (raw),
      .cfg  (cfg_r),
      .ev   (ev[i])
    );
  end

  bdlp_pick #(.NUM_BUTTONS(NUM_BUTTONS)) u_pick (
    .ev (ev),
    .res(res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = res_r.kind;
  assign out_button     = res_r.button;
  assign out_held_time  = res_r.held;
  assign out_command    = res_r.command;

`ifndef ASSERT_OFF
  // An empty event carries no button, time or command.
  a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.kind == EV_NONE) |->
      (res_r.button == '0 && res_r.held == '0 && res_r.command == CMD_NONE))
    else $error("empty event with nonzero payload");

  // Commands come only from clicks and long starts.
  a_cmd_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.command != CMD_NONE) |->
      (res_r.kind == EV_CLICK || res_r.kind == EV_LSTART))
    else $error("command on an event that maps to none");

  // A held time is reported only for hold or stop.
  a_held_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.held != '0) |->
      (res_r.kind == EV_LHOLD || res_r.kind == EV_LSTOP))
    else $error("held time on the wrong event");

  // A tick that advances always shows up as a result.
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced word missing from result register");

  // A waiting word is not dropped while the result is stalled.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |=> s1_valid_r)
    else $error("input word lost under stall");
`endif

endmodule
